### hw/rtl/prsu_pkg.sv
// shared types and constants for the pauli rotation state update core
`default_nettype none
package prsu_pkg;
  localparam int MAX_QUBITS = 10;
  localparam int MIN_QUBITS = 3;
  localparam int DEPTH = 1 << MAX_QUBITS;
  localparam int AW = MAX_QUBITS;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_WAIT,
    ST_MUL,
    ST_ACC,
    ST_WRITE,
    ST_DONE
  } state_t;

  localparam logic [0:0] REG_ACTIVE_QUBITS = 1'b0;
endpackage
`default_nettype wire

### hw/rtl/pauli_rotation_state_update_core.sv
// top level of the pauli rotation state update core
`default_nettype none
// Holds up to 1024 complex Q1.30 amplitudes and runs write, read and Pauli
// rotation commands. A command is taken when start is high and busy is low;
// its result shows for one cycle with done high and cannot be held off.
// A rotation walks the active state one pair at a time (one amplitude for
// a diagonal Pauli) through a single shared 33x32 multiplier and a single
// memory port: a pair takes two fetches (a FETCH and a WAIT state each),
// four output parts, each summed from two products, and two write beats;
// a diagonal entry takes one fetch, two parts and one beat. A 10 qubit
// rotation walks 512 pairs. A rotation with a bad pivot goes from FETCH
// straight to done. The store has no reset; unwritten entries read as garbage.
module pauli_rotation_state_update_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [9:0]  index,
  input  wire logic signed [31:0] data_real,
  input  wire logic signed [31:0] data_imag,
  input  wire logic [9:0]  x_mask,
  input  wire logic [9:0]  z_mask,
  input  wire logic [3:0]  pivot_bit,
  input  wire logic signed [31:0] cosine,
  input  wire logic signed [31:0] sine,
  input  wire logic [1:0]  phase_code,
  input  wire logic        negate_angle,
  output logic             done,
  output logic signed [31:0] read_real,
  output logic signed [31:0] read_imag,
  output logic [1:0]       done_cmd,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int AW = prsu_pkg::AW;

  // storage, one port used per cycle
  logic [63:0] mem [prsu_pkg::DEPTH];
  logic [63:0] rdata;

  logic [3:0] active_qubits;
  prsu_pkg::state_t state, state_next;

  // latched command beat
  logic [1:0]  c_cmd;
  logic [AW-1:0] c_x, c_z, c_pbit;
  logic signed [32:0] c_cos, c_base;
  logic c_imag, c_diag;
  logic c_skip;               // rotation with a bad pivot, state left alone

  logic [AW-1:0] walk;        // walk counter over base indexes
  logic [AW-1:0] w_mask;
  logic [AW-1:0] b_idx, r_idx;
  logic [63:0] lval, rval;
  logic fetch_r;              // second fetch of a pair
  logic [1:0] part;           // output part in progress
  logic mphase;               // first or second product of a part
  logic signed [65:0] prod, acc;
  logic signed [31:0] res [4];

  assign pready = 1'b1;
  assign prdata = {28'd0, active_qubits};
  assign busy = (state != prsu_pkg::ST_IDLE);

  // clamped active width
  logic [3:0] aw_eff;
  always_comb begin
    if (active_qubits < 4'(prsu_pkg::MIN_QUBITS)) aw_eff = 4'(prsu_pkg::MIN_QUBITS);
    else if (active_qubits > 4'(prsu_pkg::MAX_QUBITS)) aw_eff = 4'(prsu_pkg::MAX_QUBITS);
    else aw_eff = active_qubits;
    w_mask = AW'(({{AW{1'b0}}, 1'b1} << aw_eff) - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) active_qubits <= 4'd10;
    else if (psel && penable && pwrite && paddr[2] == prsu_pkg::REG_ACTIVE_QUBITS)
      active_qubits <= pwdata[3:0];
  end

  // current left index: insert a zero at the pivot bit (diag: plain walk)
  logic [AW-1:0] walk_lo, lo_mask;
  logic walk_end;
  always_comb begin
    walk_lo = walk;
    lo_mask = c_pbit - 1'b1;
    if (c_diag) b_idx = walk_lo;
    else b_idx = ((walk_lo & ~lo_mask) << 1) | (walk_lo & lo_mask);
    r_idx = b_idx ^ c_x;
    walk_end = c_diag ? (walk == (w_mask)) :
                        (walk == (w_mask >> 1));
  end

  // sign at the left index
  logic signed [32:0] ls;
  always_comb ls = (^(b_idx & c_z)) ? -c_base : c_base;

  // operand selection for one product: part, first/second
  logic signed [32:0] opa;
  logic signed [31:0] opb;
  logic signed [31:0] lr, li, rr, ri;
  always_comb begin
    lr = lval[63:32]; li = lval[31:0];
    rr = rval[63:32]; ri = rval[31:0];
    opa = c_cos;
    opb = lr;
    if (!mphase) begin
      opa = c_cos;
      case (part)
        2'd0: opb = lr;
        2'd1: opb = li;
        2'd2: opb = rr;
        default: opb = ri;
      endcase
    end else if (c_diag) begin
      opa = (part == 2'd0) ? ls : -ls;
      opb = (part == 2'd0) ? li : lr;
    end else if (!c_imag) begin
      case (part)
        2'd0: begin opa = ls;  opb = ri; end
        2'd1: begin opa = -ls; opb = rr; end
        2'd2: begin opa = ls;  opb = li; end
        default: begin opa = -ls; opb = lr; end
      endcase
    end else begin
      case (part)
        2'd0: begin opa = -ls; opb = rr; end
        2'd1: begin opa = -ls; opb = ri; end
        2'd2: begin opa = ls;  opb = lr; end
        default: begin opa = ls;  opb = li; end
      endcase
    end
  end

  // round half up, shift, saturate
  logic signed [65:0] rsum;
  logic signed [35:0] q;
  logic signed [31:0] sat;
  always_comb begin
    rsum = acc + prod + 66'sd536870912;
    q = 36'(rsum >>> 30);
    if (q > 36'sd2147483647) sat = 32'h7fffffff;
    else if (q < -36'sd2147483648) sat = 32'h80000000;
    else sat = q[31:0];
  end

  logic last_part;
  assign last_part = c_diag ? (part == 2'd1) : (part == 2'd3);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      prsu_pkg::ST_IDLE:
        if (start) begin
          unique case (prsu_pkg::cmd_t'(cmd))
            prsu_pkg::CMD_READ:   state_next = prsu_pkg::ST_READ;
            prsu_pkg::CMD_ROTATE: state_next = prsu_pkg::ST_FETCH;
            default:              state_next = prsu_pkg::ST_DONE;
          endcase
        end
      prsu_pkg::ST_READ:  state_next = prsu_pkg::ST_DONE;
      prsu_pkg::ST_FETCH: begin
        if (c_skip) state_next = prsu_pkg::ST_DONE;
        else state_next = prsu_pkg::ST_WAIT;
      end
      prsu_pkg::ST_WAIT:
        state_next = (c_diag || fetch_r) ? prsu_pkg::ST_MUL : prsu_pkg::ST_FETCH;
      prsu_pkg::ST_MUL:   state_next = prsu_pkg::ST_ACC;
      prsu_pkg::ST_ACC:
        if (mphase) state_next = last_part ? prsu_pkg::ST_WRITE : prsu_pkg::ST_MUL;
        else state_next = prsu_pkg::ST_MUL;
      prsu_pkg::ST_WRITE:
        if ((c_diag || fetch_r) && walk_end) state_next = prsu_pkg::ST_DONE;
        else if (c_diag || fetch_r) state_next = prsu_pkg::ST_FETCH;
        else state_next = prsu_pkg::ST_WRITE;
      prsu_pkg::ST_DONE:  state_next = prsu_pkg::ST_IDLE;
      default:            state_next = prsu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= prsu_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath and sequencing registers
  logic pivot_ok;
  logic [AW-1:0] xm;
  always_comb begin
    xm = x_mask & w_mask;
    pivot_ok = (pivot_bit < aw_eff) && xm[pivot_bit[$clog2(AW)-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
      fetch_r <= 1'b0;
      part <= 2'd0;
      mphase <= 1'b0;
    end else begin
      unique case (state)
        prsu_pkg::ST_IDLE: begin
          walk <= '0;
          fetch_r <= 1'b0;
          part <= 2'd0;
          mphase <= 1'b0;
        end
        prsu_pkg::ST_WAIT: fetch_r <= ~c_diag & ~fetch_r;
        prsu_pkg::ST_ACC: begin
          mphase <= ~mphase;
          if (mphase && !last_part) part <= part + 2'd1;
        end
        prsu_pkg::ST_WRITE: begin
          part <= 2'd0;
          // two write beats for a pair: fetch_r marks the right member pending
          if (c_diag || fetch_r) begin
            fetch_r <= 1'b0;
            walk <= walk + 1'b1;
          end else fetch_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == prsu_pkg::ST_IDLE && start) begin
      c_cmd  <= cmd;
      c_x    <= xm;
      c_z    <= z_mask & w_mask;
      c_pbit <= AW'(1) << pivot_bit[$clog2(AW)-1:0];
      c_cos  <= 33'(cosine);
      c_diag <= (xm == '0);
      c_imag <= phase_code[1];
      c_base <= ((negate_angle ^ (phase_code[0] & (xm != '0))) ?
                 -33'(sine) : 33'(sine));
      // a rotation with a bad pivot does nothing
      c_skip <= (cmd == prsu_pkg::CMD_ROTATE && xm != '0 && !pivot_ok);
    end
    if (state == prsu_pkg::ST_MUL) prod <= 66'(opa * opb);
    if (state == prsu_pkg::ST_ACC) begin
      if (!mphase) acc <= prod;
      else begin
        res[part] <= sat;
        acc <= '0;
      end
    end
    if (state == prsu_pkg::ST_WAIT) begin
      if (fetch_r) rval <= rdata;
      else lval <= rdata;
    end
    // read latch: capture memory data in the cycle after the address
    if (state == prsu_pkg::ST_READ) lval <= rdata;
  end

  // memory port: write, read-modify-write, command read
  logic        m_we;
  logic [AW-1:0] m_addr;
  logic [63:0] m_wd;
  always_comb begin
    m_we = 1'b0;
    m_addr = b_idx;
    m_wd = {res[0], res[1]};
    if (state == prsu_pkg::ST_IDLE) begin
      m_addr = index & w_mask;
      m_we = start && (cmd == prsu_pkg::CMD_WRITE);
      m_wd = {data_real, data_imag};
    end else if (state == prsu_pkg::ST_FETCH) begin
      m_addr = fetch_r ? r_idx : b_idx;
    end else if (state == prsu_pkg::ST_WRITE) begin
      m_we = 1'b1;
      m_addr = fetch_r ? r_idx : b_idx;
      m_wd = fetch_r ? {res[2], res[3]} : {res[0], res[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wd;
    rdata <= mem[m_addr];
  end

  // result beat
  always_comb begin
    done = (state == prsu_pkg::ST_DONE);
    done_cmd = c_cmd;
    read_real = '0;
    read_imag = '0;
    if (c_cmd == prsu_pkg::CMD_READ) begin
      read_real = lval[63:32];
      read_imag = lval[31:0];
    end
  end
endmodule
`default_nettype wire
